FILE: design/rpt_pkg.sv
// ----------------------------------------------------------------------------
// rpt_pkg
// Shared types and constants for the RGB pixel tint shader.
// ----------------------------------------------------------------------------
package rpt_pkg;

  localparam int unsigned SHADE_STEPS = 32;
  localparam int unsigned PIXEL_BITS  = 16;
  localparam int unsigned GAIN_FRAC   = 14;

  localparam int unsigned PIX_W   = 16;
  localparam int unsigned SHADE_W = 6;
  localparam int unsigned GAIN_W  = 16;
  localparam int unsigned SHIFT_W = 4;
  localparam int unsigned CFG_W   = 16;
  localparam int unsigned IDX_W   = 3;

  localparam int unsigned VG_W   = PIX_W + GAIN_W;
  localparam int unsigned PROD_W = VG_W + SHADE_W;
  localparam int unsigned TRIM_W = PROD_W - (GAIN_FRAC - 1);
  localparam int unsigned SUM_W  = TRIM_W + 1;

  // round to nearest: (2p + S*2^14) / (2*S*2^14) == ((p >> 13) + S) / (2*S)
  localparam int unsigned ROUND_DIV = 2 * SHADE_STEPS;

  localparam logic [PIX_W-1:0] PIX_KEEP = PIX_W'((64'd1 << PIXEL_BITS) - 64'd1);

  typedef enum logic [IDX_W-1:0] {
    REG_RED_MASK   = 3'd0,
    REG_GREEN_MASK = 3'd1,
    REG_BLUE_MASK  = 3'd2,
    REG_OFFSETS    = 3'd3,
    REG_RED_GAIN   = 3'd4,
    REG_GREEN_GAIN = 3'd5,
    REG_BLUE_GAIN  = 3'd6
  } reg_index_t;

  typedef struct packed {
    logic [PIX_W-1:0]   mask;
    logic [SHIFT_W-1:0] shift;
    logic [GAIN_W-1:0]  gain;
  } chan_cfg_t;

  typedef struct packed {
    chan_cfg_t red;
    chan_cfg_t green;
    chan_cfg_t blue;
  } shade_cfg_t;

endpackage

FILE: design/rpt_cfg_regs.sv
// ----------------------------------------------------------------------------
// rpt_cfg_regs
// Configuration register file: field masks, field shifts and tint gains.
// ----------------------------------------------------------------------------
module rpt_cfg_regs (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_write,
  input  logic [rpt_pkg::IDX_W-1:0] cfg_index,
  input  logic [rpt_pkg::CFG_W-1:0] cfg_data,
  output rpt_pkg::shade_cfg_t       cfg
);
  import rpt_pkg::*;

  logic [PIX_W-1:0]     sel_red;
  logic [PIX_W-1:0]     sel_green;
  logic [PIX_W-1:0]     sel_blue;
  logic [3*SHIFT_W-1:0] offsets;
  logic [GAIN_W-1:0]    red_gain;
  logic [GAIN_W-1:0]    green_gain;
  logic [GAIN_W-1:0]    blue_gain;

  always_ff @(posedge clk) begin
    if (rst) begin
      sel_red    <= 16'hF800;
      sel_green  <= 16'h07E0;
      sel_blue   <= 16'h001F;
      offsets    <= 12'hB50;
      red_gain   <= 16'd16384;
      green_gain <= 16'd16384;
      blue_gain  <= 16'd16384;
    end else if (cfg_write) begin
      case (reg_index_t'(cfg_index))
        REG_RED_MASK:   sel_red    <= cfg_data;
        REG_GREEN_MASK: sel_green  <= cfg_data;
        REG_BLUE_MASK:  sel_blue   <= cfg_data;
        REG_OFFSETS:    offsets    <= cfg_data[3*SHIFT_W-1:0];
        REG_RED_GAIN:   red_gain   <= cfg_data;
        REG_GREEN_GAIN: green_gain <= cfg_data;
        REG_BLUE_GAIN:  blue_gain  <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    cfg.red.mask    = sel_red;
    cfg.red.shift   = offsets[3*SHIFT_W-1:2*SHIFT_W];
    cfg.red.gain    = red_gain;
    cfg.green.mask  = sel_green;
    cfg.green.shift = offsets[2*SHIFT_W-1:SHIFT_W];
    cfg.green.gain  = green_gain;
    cfg.blue.mask   = sel_blue;
    cfg.blue.shift  = offsets[SHIFT_W-1:0];
    cfg.blue.gain   = blue_gain;
  end

endmodule

FILE: design/rpt_channel.sv
// ----------------------------------------------------------------------------
// rpt_channel
// One color channel: extract, scale by gain, scale by shade, round, repack.
// Four register stages; the repacked field is combinational off the last.
// ----------------------------------------------------------------------------
module rpt_channel (
  input  logic                        clk,
  input  logic [rpt_pkg::PIX_W-1:0]   pixel,
  input  logic [rpt_pkg::SHADE_W-1:0] shade,
  input  rpt_pkg::chan_cfg_t          cfg,
  output logic [rpt_pkg::PIX_W-1:0]   field
);
  import rpt_pkg::*;

  logic [PIX_W-1:0]   chan_s1;
  logic [SHADE_W-1:0] shade_s1;
  logic [VG_W-1:0]    vg_s2;
  logic [SHADE_W-1:0] shade_s2;
  logic [TRIM_W-1:0]  prod_s3;
  logic [PIX_W-1:0]   level_s4;
  logic [SUM_W-1:0]   round_sum;
  logic [PIX_W-1:0]   round_quo;

  assign round_sum = SUM_W'(prod_s3) + SUM_W'(SHADE_STEPS);
  assign round_quo = PIX_W'(round_sum / ROUND_DIV);

  always_ff @(posedge clk) begin
    chan_s1  <= (pixel & cfg.mask) >> cfg.shift;
    shade_s1 <= shade;
    vg_s2    <= VG_W'(chan_s1) * VG_W'(cfg.gain);
    shade_s2 <= shade_s1;
    prod_s3  <= TRIM_W'((PROD_W'(vg_s2) * PROD_W'(shade_s2)) >> (GAIN_FRAC - 1));
    level_s4 <= round_quo;
  end

  assign field = (level_s4 << cfg.shift) & cfg.mask;

endmodule

FILE: design/rgb_pixel_tint_shader.sv
// ----------------------------------------------------------------------------
// rgb_pixel_tint_shader
// Each start travels through the channel register stages and the output register to done.
// Throughput: one item per cycle; three channel pipelines run in parallel.
// busy is high only during reset; the result cannot be stalled.
// Reset restores the register defaults and drops all items in flight.
// ----------------------------------------------------------------------------
module rgb_pixel_tint_shader (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  logic [rpt_pkg::PIX_W-1:0]   source_pixel,
  input  logic [rpt_pkg::SHADE_W-1:0] shade_level,
  output logic                        done,
  output logic [rpt_pkg::PIX_W-1:0]   lit_pixel,
  input  logic                        cfg_write,
  input  logic [rpt_pkg::IDX_W-1:0]   cfg_index,
  input  logic [rpt_pkg::CFG_W-1:0]   cfg_data
);
  import rpt_pkg::*;

  localparam int unsigned DEPTH = 4;

  shade_cfg_t       cfg;
  logic [PIX_W-1:0] pixel_in;
  logic [PIX_W-1:0] red_field;
  logic [PIX_W-1:0] green_field;
  logic [PIX_W-1:0] blue_field;
  logic [DEPTH-1:0] vld;

  assign busy     = rst;
  assign pixel_in = source_pixel & PIX_KEEP;

  rpt_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  rpt_channel u_red (
    .clk   (clk),
    .pixel (pixel_in),
    .shade (shade_level),
    .cfg   (cfg.red),
    .field (red_field)
  );

  rpt_channel u_green (
    .clk   (clk),
    .pixel (pixel_in),
    .shade (shade_level),
    .cfg   (cfg.green),
    .field (green_field)
  );

  rpt_channel u_blue (
    .clk   (clk),
    .pixel (pixel_in),
    .shade (shade_level),
    .cfg   (cfg.blue),
    .field (blue_field)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      vld  <= '0;
      done <= 1'b0;
    end else begin
      vld  <= {vld[DEPTH-2:0], start};
      done <= vld[DEPTH-1];
    end
  end

  always_ff @(posedge clk) begin
    lit_pixel <= (red_field | green_field | blue_field) & PIX_KEEP;
  end

endmodule
